/* rtl/swhsr_pkg.sv */
// shared types, constants and helpers for the single-wire humidity sensor receiver
// no dependencies; used by every module in rtl/ through scoped names
`default_nettype none

package swhsr_pkg;

   localparam int FRAME_BITS = 40;
   localparam int CNT_WIDTH  = 15;
   localparam int BITS_WIDTH = $clog2(FRAME_BITS + 1);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 15;
   localparam int SHOWN_WIDTH = 12;

   localparam logic [CNT_WIDTH-1:0] CNT_MAX = {CNT_WIDTH{1'b1}};

   // error display: 1000 * error + 666
   localparam logic [SHOWN_WIDTH-1:0] SHOWN_ERR_STEP   = 12'd1000;
   localparam logic [SHOWN_WIDTH-1:0] SHOWN_ERR_OFFSET = 12'd666;

   // register reset values
   localparam logic [14:0] START_LOW_RESET    = 15'd18000;
   localparam logic [7:0]  FIRST_CHECK_RESET  = 8'd60;
   localparam logic [7:0]  SECOND_CHECK_RESET = 8'd80;
   localparam logic [7:0]  PULSE_MIN_RESET    = 8'd13;
   localparam logic [7:0]  ZERO_MAX_RESET     = 8'd35;
   localparam logic [7:0]  ONE_MIN_RESET      = 8'd60;
   localparam logic [7:0]  PULSE_MAX_RESET    = 8'd80;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      REG_START_LOW    = 3'd0,
      REG_FIRST_CHECK  = 3'd1,
      REG_SECOND_CHECK = 3'd2,
      REG_PULSE_MIN    = 3'd3,
      REG_ZERO_MAX     = 3'd4,
      REG_ONE_MIN      = 3'd5,
      REG_PULSE_MAX    = 3'd6,
      REG_SHOW_HUMID   = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_NO_LOW  = 2'd1,
      ERR_NO_HIGH = 2'd2,
      ERR_PULSE   = 2'd3
   } error_type;

   typedef struct packed {
      logic [14:0] start_low_us;
      logic [7:0]  first_check_us;
      logic [7:0]  second_check_us;
      logic [7:0]  pulse_min_us;
      logic [7:0]  zero_max_us;
      logic [7:0]  one_min_us;
      logic [7:0]  pulse_max_us;
      logic        show_humidity;
   } cfg_type;

   typedef struct packed {
      logic                   drive_low;
      logic                   done_res;
      logic [1:0]             error_code;
      logic [7:0]             humidity;
      logic [7:0]             temperature;
      logic [SHOWN_WIDTH-1:0] shown_value;
   } rsp_type;

   function automatic logic [SHOWN_WIDTH-1:0] shown_value_f(
      input logic [1:0] err,
      input logic [7:0] hum,
      input logic [7:0] temp,
      input logic       sel_hum
   );
      logic [SHOWN_WIDTH-1:0] val;
      if (err != ERR_NONE) begin
         val = SHOWN_WIDTH'(SHOWN_WIDTH'(err) * SHOWN_ERR_STEP) + SHOWN_ERR_OFFSET;
      end else if (sel_hum) begin
         val = SHOWN_WIDTH'(hum);
      end else begin
         val = SHOWN_WIDTH'(temp);
      end
      return val;
   endfunction

endpackage

`default_nettype wire

/* rtl/swhsr_cfg.sv */
// configuration register bank for the humidity sensor receiver
// depends on swhsr_pkg
`default_nettype none

module swhsr_cfg (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [swhsr_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  wire logic [swhsr_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output swhsr_pkg::cfg_type                          cfg
);

   swhsr_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (swhsr_pkg::reg_index_type'(csr_addr))
            swhsr_pkg::REG_START_LOW:    cfg_in.start_low_us    = csr_wdata[14:0];
            swhsr_pkg::REG_FIRST_CHECK:  cfg_in.first_check_us  = csr_wdata[7:0];
            swhsr_pkg::REG_SECOND_CHECK: cfg_in.second_check_us = csr_wdata[7:0];
            swhsr_pkg::REG_PULSE_MIN:    cfg_in.pulse_min_us    = csr_wdata[7:0];
            swhsr_pkg::REG_ZERO_MAX:     cfg_in.zero_max_us     = csr_wdata[7:0];
            swhsr_pkg::REG_ONE_MIN:      cfg_in.one_min_us      = csr_wdata[7:0];
            swhsr_pkg::REG_PULSE_MAX:    cfg_in.pulse_max_us    = csr_wdata[7:0];
            swhsr_pkg::REG_SHOW_HUMID:   cfg_in.show_humidity   = csr_wdata[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_us    <= swhsr_pkg::START_LOW_RESET;
         cfg_ff.first_check_us  <= swhsr_pkg::FIRST_CHECK_RESET;
         cfg_ff.second_check_us <= swhsr_pkg::SECOND_CHECK_RESET;
         cfg_ff.pulse_min_us    <= swhsr_pkg::PULSE_MIN_RESET;
         cfg_ff.zero_max_us     <= swhsr_pkg::ZERO_MAX_RESET;
         cfg_ff.one_min_us      <= swhsr_pkg::ONE_MIN_RESET;
         cfg_ff.pulse_max_us    <= swhsr_pkg::PULSE_MAX_RESET;
         cfg_ff.show_humidity   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/swhsr_core.sv */
// protocol sequencer: start pulse, reply checks, pulse timing and frame capture
// depends on swhsr_pkg; one request is processed per accepted tick
`default_nettype none

module swhsr_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               start_req,
   input  wire logic               line_level,
   input  wire swhsr_pkg::cfg_type cfg,
   output swhsr_pkg::rsp_type      rsp
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LOW    = 3'd1,
      PH_FIRST  = 3'd2,
      PH_SECOND = 3'd3,
      PH_FALL   = 3'd4,
      PH_RISE   = 3'd5,
      PH_HIGH   = 3'd6
   } phase_type;

   localparam int CW = swhsr_pkg::CNT_WIDTH;
   localparam int BW = swhsr_pkg::BITS_WIDTH;
   localparam int FB = swhsr_pkg::FRAME_BITS;

   phase_type         phase_ff, phase_in;
   logic [CW-1:0]     tick_ff, tick_in;
   logic [BW-1:0]     bits_ff, bits_in;
   logic [FB-1:0]     frame_ff, frame_in;
   logic [7:0]        hum_ff, hum_in;
   logic [7:0]        temp_ff, temp_in;
   logic [1:0]        err_ff, err_in;
   logic              drive;
   logic              done;
   logic              is_zero;
   logic              is_one;
   logic              bad_width;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bits_in   = bits_ff;
      frame_in  = frame_ff;
      hum_in    = hum_ff;
      temp_in   = temp_ff;
      err_in    = err_ff;
      drive     = 1'b0;
      done      = 1'b0;
      is_zero   = tick_ff < CW'(cfg.zero_max_us);
      is_one    = tick_ff > CW'(cfg.one_min_us);
      bad_width = (tick_ff <= CW'(cfg.pulse_min_us)) || (tick_ff >= CW'(cfg.pulse_max_us));

      // a start request aborts whatever reading is running
      if (start_req) begin
         phase_in = PH_LOW;
         tick_in  = '0;
         bits_in  = '0;
         frame_in = '0;
      end

      case (phase_in)
         PH_LOW: begin
            if (tick_in < cfg.start_low_us) begin
               drive   = 1'b1;
               tick_in = tick_in + 1'b1;
            end
            if (tick_in >= cfg.start_low_us) begin
               phase_in = PH_FIRST;
               tick_in  = '0;
            end
         end
         PH_FIRST: begin
            if (tick_in < swhsr_pkg::CNT_MAX) tick_in = tick_in + 1'b1;
            if (tick_in >= CW'(cfg.first_check_us)) begin
               if (line_level) begin
                  err_in   = swhsr_pkg::ERR_NO_LOW;
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_SECOND;
                  tick_in  = '0;
               end
            end
         end
         PH_SECOND: begin
            if (tick_in < swhsr_pkg::CNT_MAX) tick_in = tick_in + 1'b1;
            if (tick_in >= CW'(cfg.second_check_us)) begin
               if (!line_level) begin
                  err_in   = swhsr_pkg::ERR_NO_HIGH;
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_FALL;
                  tick_in  = '0;
               end
            end
         end
         PH_FALL: begin
            if (!line_level) phase_in = PH_RISE;
         end
         PH_RISE: begin
            if (line_level) begin
               phase_in = PH_HIGH;
               tick_in  = CW'(1);
            end
         end
         PH_HIGH: begin
            // high phase is never entered on a start tick, so tick_ff is the width
            if (line_level) begin
               if (tick_in < swhsr_pkg::CNT_MAX) tick_in = tick_in + 1'b1;
            end else if (bad_width || !(is_zero || is_one)) begin
               err_in   = swhsr_pkg::ERR_PULSE;
               phase_in = PH_IDLE;
               tick_in  = '0;
               done     = 1'b1;
            end else begin
               frame_in = {frame_in[FB-2:0], ~is_zero};
               bits_in  = bits_in + 1'b1;
               tick_in  = '0;
               if (bits_in >= BW'(FB)) begin
                  err_in   = swhsr_pkg::ERR_NONE;
                  hum_in   = frame_in[FB-1 -: 8];
                  temp_in  = frame_in[FB-17 -: 8];
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_RISE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bits_ff  <= '0;
         frame_ff <= '0;
         hum_ff   <= '0;
         temp_ff  <= '0;
         err_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bits_ff  <= bits_in;
         frame_ff <= frame_in;
         hum_ff   <= hum_in;
         temp_ff  <= temp_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      rsp.drive_low   = drive;
      rsp.done_res    = done;
      rsp.error_code  = err_in;
      rsp.humidity    = hum_in;
      rsp.temperature = temp_in;
      rsp.shown_value = swhsr_pkg::shown_value_f(err_in, hum_in, temp_in, cfg.show_humidity);
   end

   // a finished reading leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> (phase_ff == PH_IDLE))
      else $error("sequencer not idle after a finished reading");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BW'(FB))
      else $error("bit count past frame length");

   // the line is only driven during the start pulse
   a_drive_low: assert property (@(posedge clock) disable iff (reset)
      drive |-> (phase_in == PH_LOW || phase_in == PH_FIRST))
      else $error("line driven outside the start pulse");

endmodule

`default_nettype wire

/* rtl/swhsr_skid.sv */
// two-entry output buffer: response register plus skid register
// depends on swhsr_pkg; decouples rsp_tready from request acceptance
`default_nettype none

module swhsr_skid (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire swhsr_pkg::rsp_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output swhsr_pkg::rsp_type      out_data,
   input  wire logic               out_ready
);

   logic               main_valid_ff, main_valid_in;
   logic               spare_valid_ff, spare_valid_in;
   swhsr_pkg::rsp_type main_ff, main_in;
   swhsr_pkg::rsp_type spare_ff, spare_in;
   logic               take;

   assign take = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            spare_in       = in_data;
            spare_valid_in = 1'b1;
         end
      end else if (take) begin
         if (spare_valid_ff) begin
            main_in        = spare_ff;
            spare_valid_in = 1'b0;
         end else begin
            main_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

   assign in_ready  = !spare_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   a_spare_needs_main: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a response entry");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !spare_valid_ff)
      else $error("request accepted with output buffer full");

   a_hold_unread: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> main_valid_ff)
      else $error("unread response dropped");

endmodule

`default_nettype wire

/* rtl/single_wire_humidity_sensor_receiver_unit.sv */
// top level: single-wire humidity/temperature sensor receiver, one request per line tick
// output: each response is registered in the output buffer and held on rsp_* until rsp_tready takes it
// throughput: one request per cycle; the two-entry output buffer keeps req_tready high
//    while a single response waits, and drops it only when both entries are full
// reset (synchronous): registers return to defaults, the reading sequencer goes idle,
//    held humidity, temperature and error clear, and the output buffer empties
`default_nettype none

module single_wire_humidity_sensor_receiver_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [7:0]                            req_tdata,  // start_req, line_level
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // drive_low, error_code, humidity, temperature, shown_value
   output logic [31:0]                                rsp_tdata,
   output logic                                       rsp_tlast,  // done_res
   input  wire logic                                  csr_we,
   input  wire logic [swhsr_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [swhsr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   swhsr_pkg::cfg_type cfg;
   swhsr_pkg::rsp_type core_rsp;
   swhsr_pkg::rsp_type out_rsp;
   logic               accept;

   assign accept = req_tvalid && req_tready;

   swhsr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swhsr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .start_req  (req_tdata[0]),
      .line_level (req_tdata[1]),
      .cfg        (cfg),
      .rsp        (core_rsp)
   );

   swhsr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (core_rsp),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, out_rsp.shown_value, out_rsp.temperature, out_rsp.humidity,
                       out_rsp.error_code, out_rsp.drive_low};
   assign rsp_tlast = out_rsp.done_res;

endmodule

`default_nettype wire

/* tb/sv/swhsr_reading_checker.sv */
// checker for the single-wire humidity sensor receiver: tracks register writes, predicts
// each tick's response and compares it with what leaves rsp_*. depends on swhsr_pkg only
module swhsr_reading_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   input  wire logic                                  req_tready,
   input  wire logic [7:0]                            req_tdata,  // start_req, line_level
   input  wire logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // drive_low, error_code, humidity, temperature, shown_value
   input  wire logic [31:0]                           rsp_tdata,
   input  wire logic                                  rsp_tlast,  // done_res
   input  wire logic                                  csr_we,
   input  wire logic [swhsr_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [swhsr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                         mismatches,
   output int                                         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import swhsr_pkg::*;

   typedef enum logic [2:0] {
      RX_IDLE, RX_HOLD_LOW, RX_FIRST_CHECK, RX_SECOND_CHECK,
      RX_WAIT_FALL, RX_WAIT_RISE, RX_PULSE_HIGH
   } rx_phase_type;

   cfg_type                cfg;
   rx_phase_type           rx_phase;
   logic [CNT_WIDTH-1:0]   tick_count;
   logic [5:0]             bits_received;
   logic [FRAME_BITS-1:0]  frame_shift;
   logic [7:0]             held_humidity;
   logic [7:0]             held_temperature;
   error_type              held_error;
   rsp_type                expected_ticks[$];
   int                     tick_number;

   task automatic end_reading(input error_type err);
      held_error = err;
      if (err == ERR_NONE) begin
         held_humidity = frame_shift[39:32];
         held_temperature = frame_shift[23:16];
      end
      rx_phase = RX_IDLE;
      tick_count = '0;
   endtask

   task automatic predict_tick(input logic start_req, input logic line, output rsp_type r);
      logic                  drive;
      logic                  done;
      logic [CNT_WIDTH-1:0]  width;
      drive = 1'b0;
      done = 1'b0;
      if (start_req) begin
         rx_phase = RX_HOLD_LOW;
         tick_count = '0;
         bits_received = '0;
         frame_shift = '0;
      end
      case (rx_phase)
         RX_HOLD_LOW: begin
            if (tick_count < cfg.start_low_us) begin
               drive = 1'b1;
               tick_count++;
            end
            if (tick_count >= cfg.start_low_us) begin
               rx_phase = RX_FIRST_CHECK;
               tick_count = '0;
            end
         end
         RX_FIRST_CHECK: begin
            if (tick_count != CNT_MAX) tick_count++;
            if (tick_count >= cfg.first_check_us) begin
               if (line) begin
                  end_reading(ERR_NO_LOW);
                  done = 1'b1;
               end else begin
                  rx_phase = RX_SECOND_CHECK;
                  tick_count = '0;
               end
            end
         end
         RX_SECOND_CHECK: begin
            if (tick_count != CNT_MAX) tick_count++;
            if (tick_count >= cfg.second_check_us) begin
               if (!line) begin
                  end_reading(ERR_NO_HIGH);
                  done = 1'b1;
               end else begin
                  rx_phase = RX_WAIT_FALL;
                  tick_count = '0;
               end
            end
         end
         RX_WAIT_FALL: begin
            if (!line) rx_phase = RX_WAIT_RISE;
         end
         RX_WAIT_RISE: begin
            if (line) begin
               rx_phase = RX_PULSE_HIGH;
               tick_count = 1;
            end
         end
         RX_PULSE_HIGH: begin
            if (line) begin
               if (tick_count != CNT_MAX) tick_count++;
            end else begin
               width = tick_count;
               // a width between the zero and one windows is treated like an out-of-range one
               if (width <= cfg.pulse_min_us || width >= cfg.pulse_max_us ||
                   (width >= cfg.zero_max_us && width <= cfg.one_min_us)) begin
                  end_reading(ERR_PULSE);
                  done = 1'b1;
               end else begin
                  frame_shift = {frame_shift[FRAME_BITS-2:0], width >= cfg.zero_max_us};
                  bits_received = bits_received + 6'd1;
                  tick_count = '0;
                  if (bits_received >= FRAME_BITS) begin
                     end_reading(ERR_NONE);
                     done = 1'b1;
                  end else begin
                     rx_phase = RX_WAIT_RISE;
                  end
               end
            end
         end
         default: rx_phase = RX_IDLE;
      endcase
      r.drive_low = drive;
      r.done_res = done;
      r.error_code = held_error;
      r.humidity = held_humidity;
      r.temperature = held_temperature;
      if (held_error != ERR_NONE)
         r.shown_value = SHOWN_WIDTH'(int'(held_error) * 1000 + 666);
      else
         r.shown_value = cfg.show_humidity ? SHOWN_WIDTH'(held_humidity)
                                           : SHOWN_WIDTH'(held_temperature);
   endtask

   task automatic compare_tick(input rsp_type exp);
      rsp_type got;
      got.drive_low = rsp_tdata[0];
      got.done_res = rsp_tlast;
      got.error_code = rsp_tdata[2:1];
      got.humidity = rsp_tdata[10:3];
      got.temperature = rsp_tdata[18:11];
      got.shown_value = rsp_tdata[30:19];
      if (got !== exp || rsp_tdata[31] !== 1'b0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tick %0d: drive %0d/%0d done %0d/%0d err %0d/%0d hum %0d/%0d temp %0d/%0d shown %0d/%0d pad %0b (exp/got)",
                     tick_number, exp.drive_low, got.drive_low, exp.done_res, got.done_res,
                     exp.error_code, got.error_code, exp.humidity, got.humidity,
                     exp.temperature, got.temperature, exp.shown_value, got.shown_value,
                     rsp_tdata[31]);
      end
   endtask

   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         cfg = '{START_LOW_RESET, FIRST_CHECK_RESET, SECOND_CHECK_RESET, PULSE_MIN_RESET,
                 ZERO_MAX_RESET, ONE_MIN_RESET, PULSE_MAX_RESET, 1'b0};
         rx_phase = RX_IDLE;
         tick_count = '0;
         bits_received = '0;
         frame_shift = '0;
         held_humidity = '0;
         held_temperature = '0;
         held_error = ERR_NONE;
         expected_ticks.delete();
         tick_number = 0;
         mismatches = 0;
      end else begin
         // the response leaving now belongs to an earlier request, so retire it first
         if (rsp_tvalid && rsp_tready) begin
            if (expected_ticks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response with no request outstanding");
            end else begin
               compare_tick(expected_ticks.pop_front());
               tick_number++;
            end
         end
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_START_LOW:    cfg.start_low_us = csr_wdata;
               REG_FIRST_CHECK:  cfg.first_check_us = csr_wdata[7:0];
               REG_SECOND_CHECK: cfg.second_check_us = csr_wdata[7:0];
               REG_PULSE_MIN:    cfg.pulse_min_us = csr_wdata[7:0];
               REG_ZERO_MAX:     cfg.zero_max_us = csr_wdata[7:0];
               REG_ONE_MIN:      cfg.one_min_us = csr_wdata[7:0];
               REG_PULSE_MAX:    cfg.pulse_max_us = csr_wdata[7:0];
               REG_SHOW_HUMID:   cfg.show_humidity = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[0], req_tdata[1], exp);
            expected_ticks.push_back(exp);
         end
      end
      outstanding <= expected_ticks.size();
   end

endmodule

/* tb/sv/tb.sv */
// top of the humidity sensor receiver regression: clock, reset, register settings and
// line-tick stimulus; swhsr_reading_checker does the prediction. needs swhsr_pkg and the rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swhsr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int WIDTH_ZERO = 0;
   localparam int WIDTH_ONE  = 1;
   localparam int WIDTH_BAD  = 2;

   typedef enum int {
      READ_GOOD, READ_NO_LOW, READ_NO_HIGH, READ_BAD_PULSE, READ_ABORT, READ_NOISE
   } reading_kind_type;

   typedef enum int {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = '0;  // start_req, line_level
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // drive_low, error_code, humidity, temperature, shown_value
   logic [31:0]                rsp_tdata;
   logic                       rsp_tlast;  // done_res
   logic                       csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]  csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   int                         mismatches;
   int                         outstanding;

   cfg_type     setting;
   logic [1:0]  tick_plan[$];  // {line_level, start_req}
   int          burst_left = 0;
   int          cycles = 0;
   flow_type    flow = FLOW_OPEN;
   int          flow_left = 0;
   int          flow_phase = 0;

   single_wire_humidity_sensor_receiver_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   swhsr_reading_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure switches at random among open, light, heavy and periodic flow
   always @(posedge clock) begin
      flow_phase <= flow_phase + 1;
      if (flow_left == 0) begin
         flow <= flow_type'($urandom_range(0, 3));
         flow_left <= $urandom_range(8, 96);
      end else begin
         flow_left <= flow_left - 1;
      end
      case (flow)
         FLOW_OPEN:     rsp_tready <= 1'b1;
         FLOW_LIGHT:    rsp_tready <= ($urandom_range(0, 3) != 0);
         FLOW_HEAVY:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default:       rsp_tready <= (flow_phase % 5) < 3;
      endcase
   end

   task automatic plan_tick(input logic start_req, input logic line);
      tick_plan.push_back({line, start_req});
   endtask

   function automatic int width_class(input int w);
      if (w <= setting.pulse_min_us || w >= setting.pulse_max_us) return WIDTH_BAD;
      if (w < setting.zero_max_us) return WIDTH_ZERO;
      if (w > setting.one_min_us) return WIDTH_ONE;
      return WIDTH_BAD;
   endfunction

   function automatic int pick_width(input int want);
      int w;
      int top;
      top = (setting.pulse_max_us > 17) ? 20 : setting.pulse_max_us + 3;
      for (int i = 0; i < 100; i++) begin
         w = $urandom_range(1, top);
         if (width_class(w) == want) return w;
      end
      return (setting.pulse_max_us == 0) ? 1 : setting.pulse_max_us;
   endfunction

   task automatic plan_reading(input reading_kind_type kind);
      logic [FRAME_BITS-1:0] payload;
      int pick;
      int bad_bit;
      int w;
      if (kind == READ_NOISE) begin
         repeat ($urandom_range(3, 30)) plan_tick($urandom_range(0, 15) == 0, $urandom_range(0, 1));
         return;
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) payload = '1;
      else if (pick == 1) payload = '0;
      else payload = {8'($urandom), 32'($urandom)};
      plan_tick(1'b1, $urandom_range(0, 1));
      // the line is not looked at while the block drives it
      for (int i = 1; i < setting.start_low_us; i++) plan_tick(1'b0, $urandom_range(0, 1));
      repeat ((setting.first_check_us == 0) ? 0 : setting.first_check_us - 1)
         plan_tick(1'b0, $urandom_range(0, 1));
      plan_tick(1'b0, kind == READ_NO_LOW);
      if (kind == READ_NO_LOW) return;
      repeat ((setting.second_check_us == 0) ? 0 : setting.second_check_us - 1)
         plan_tick(1'b0, $urandom_range(0, 1));
      plan_tick(1'b0, kind != READ_NO_HIGH);
      if (kind == READ_NO_HIGH) return;
      repeat ($urandom_range(0, 2)) plan_tick(1'b0, 1'b1);
      plan_tick(1'b0, 1'b0);
      bad_bit = (kind == READ_BAD_PULSE) ? $urandom_range(0, FRAME_BITS - 1) : -1;
      for (int b = 0; b < FRAME_BITS; b++) begin
         repeat ($urandom_range(0, 1)) plan_tick(1'b0, 1'b0);
         if (b == bad_bit) w = pick_width(WIDTH_BAD);
         else w = pick_width(payload[FRAME_BITS-1-b] ? WIDTH_ONE : WIDTH_ZERO);
         repeat (w) plan_tick(1'b0, 1'b1);
         plan_tick(1'b0, 1'b0);
         if (b == bad_bit) return;
      end
      repeat ($urandom_range(0, 3)) plan_tick(1'b0, $urandom_range(0, 1));
   endtask

   task automatic send_tick(input logic [1:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, code};
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic send_plan();
      while (tick_plan.size() != 0) send_tick(tick_plan.pop_front());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_setting(input cfg_type s);
      reg_index_type idx;
      logic [CSR_DATA_WIDTH-1:0] value;
      for (int i = 0; i < 8; i++) begin
         idx = reg_index_type'(i);
         case (idx)
            REG_START_LOW:    value = s.start_low_us;
            REG_FIRST_CHECK:  value = s.first_check_us;
            REG_SECOND_CHECK: value = s.second_check_us;
            REG_PULSE_MIN:    value = s.pulse_min_us;
            REG_ZERO_MAX:     value = s.zero_max_us;
            REG_ONE_MIN:      value = s.one_min_us;
            REG_PULSE_MAX:    value = s.pulse_max_us;
            default:          value = s.show_humidity;
         endcase
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      setting = s;
   endtask

   task automatic run_readings(input int budget, input bit pause_midway);
      int sent;
      int roll;
      int cut;
      reading_kind_type kind;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 66) kind = READ_GOOD;
         else if (roll < 74) kind = READ_NO_LOW;
         else if (roll < 82) kind = READ_NO_HIGH;
         else if (roll < 90) kind = READ_BAD_PULSE;
         else if (roll < 96) kind = READ_ABORT;
         else kind = READ_NOISE;
         plan_reading(kind);
         // an aborted reading is cut short and the next start restarts the block mid-frame
         if (kind == READ_ABORT) begin
            cut = $urandom_range(2, tick_plan.size() - 1);
            while (tick_plan.size() > cut) void'(tick_plan.pop_back());
         end
         sent += tick_plan.size();
         send_plan();
         if (pause_midway && sent >= budget / 2) begin
            drain();
            pause_midway = 1'b0;
         end
      end
   endtask

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("single_wire_humidity_sensor_receiver_unit regression: fail");
      $finish;
   end

   initial begin
      string script;
      setting = '{START_LOW_RESET, FIRST_CHECK_RESET, SECOND_CHECK_RESET, PULSE_MIN_RESET,
                  ZERO_MAX_RESET, ONE_MIN_RESET, PULSE_MAX_RESET, 1'b0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: idle ticks, then the start of a long drive-low period
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b1);
      plan_tick(1'b1, 1'b1);
      repeat (20) plan_tick(1'b0, $urandom_range(0, 1));
      send_plan();
      drain();

      // S start, T start with line high, 0/1 plain line level
      // no low reply, no high reply, width in the gap, width at minimum, restart while busy
      program_setting('{15'd1, 8'd1, 8'd1, 8'd1, 8'd3, 8'd4, 8'd6, 1'b1});
      script = "01S1S00S0101110S01010TS1";
      for (int i = 0; i < script.len(); i++) begin
         case (script[i])
            "S":     plan_tick(1'b1, 1'b0);
            "T":     plan_tick(1'b1, 1'b1);
            "0":     plan_tick(1'b0, 1'b0);
            default: plan_tick(1'b0, 1'b1);
         endcase
      end
      send_plan();
      drain();

      program_setting('{15'd1, 8'd1, 8'd2, 8'd0, 8'd2, 8'd2, 8'd5, 1'b1});
      run_readings(50, 1'b0);
      drain();
      program_setting('{15'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd1, 8'd3, 1'b0});
      run_readings(50, 1'b0);
      drain();

      // longest drive-low, abandoned by the next setting
      program_setting('{15'd32767, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0});
      plan_tick(1'b1, 1'b1);
      repeat (16) plan_tick(1'b0, $urandom_range(0, 1));
      send_plan();
      drain();
      program_setting('{15'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0});
      run_readings(30, 1'b0);
      drain();

      program_setting('{15'd2, 8'd3, 8'd1, 8'd1, 8'd3, 8'd2, 8'd5, 1'b0});
      run_readings(50, 1'b1);
      drain();
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("single_wire_humidity_sensor_receiver_unit regression: pass");
      else
         $display("single_wire_humidity_sensor_receiver_unit regression: fail");
      $finish;
   end

endmodule

/* sim.f */
rtl/swhsr_pkg.sv
rtl/swhsr_cfg.sv
rtl/swhsr_core.sv
rtl/swhsr_skid.sv
rtl/single_wire_humidity_sensor_receiver_unit.sv
tb/sv/swhsr_reading_checker.sv
tb/sv/tb.sv
